/* src/mpfq_pkg.sv */
`default_nettype none
package mpfq_pkg;

  localparam int LEVELS      = 8;
  localparam int LEVEL_DEPTH = 16;

  localparam int PRI_W   = 4;
  localparam int ID_W    = 16;
  localparam int ENTRY_W = ID_W + 1;
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int HEAD_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ADDR_W  = $clog2(LEVELS * LEVEL_DEPTH);
  localparam int SDATA_W = 24;
  localparam int MDATA_W = 24;
  localparam int MDATA_PAD = MDATA_W - ENTRY_W - PRI_W;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPRI = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } command_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } mpfq_cmd_t;

  typedef struct packed {
    logic out_free;
  } mpfq_stat_t;

endpackage
`default_nettype wire

/* src/multilevel_priority_fifo_queue_unit.sv */
// Strict-priority ready queue with one FIFO per priority level.
// Input channel s_*: s_tuser is the command (0 enqueue, 1 dequeue); s_tdata
// carries the priority, the task id and the ready flag of an enqueue.
// Output channel m_*: one beat per input beat, in order. m_tuser is the status
// (0 ok, 1 level full, 2 queue empty, 3 bad priority); m_tdata carries the
// dequeued task id, its ready flag and its level, all zero otherwise.
// A result is registered in steps: the accepting edge captures the request;
// in the execute state the priority encoder picks the level, the level
// memory is written or read and the result is registered; the output
// register is then loaded from the result once it is free.
// The controller passes through its three states, idle, execute and done,
// for each beat, and accepts no new beat until it is back in idle.
// The output register lets the next beat be accepted while a result waits.
// If the receiver stalls, the finished result of the following beat is held
// inside and no further beat is accepted until the output register frees.
// Reset empties every level and drops any pending result; the memory itself
// is not cleared, since only written slots are ever read.
`default_nettype none
module multilevel_priority_fifo_queue_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [3:0] priority_req, [19:4] task_id, [20] task_ready, [23:21] zero.
  input  wire logic [mpfq_pkg::SDATA_W-1:0] s_tdata,
  // [0] command.
  input  wire logic                         s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [15:0] out_task_id, [16] out_task_ready, [20:17] out_priority, [23:21] zero.
  output logic [mpfq_pkg::MDATA_W-1:0]      m_tdata,
  // [1:0] status.
  output logic [1:0]                        m_tuser
);
  import mpfq_pkg::*;

  mpfq_cmd_t  cmd;
  mpfq_stat_t stat;

  mpfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpfq_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

/* src/mpfq_ctrl.sv */
`default_nettype none
module mpfq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire mpfq_pkg::mpfq_stat_t stat,
  output mpfq_pkg::mpfq_cmd_t     cmd
);
  import mpfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* src/mpfq_dpath.sv */
`default_nettype none
module mpfq_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mpfq_pkg::mpfq_cmd_t           cmd,
  output mpfq_pkg::mpfq_stat_t               stat,
  input  wire logic [mpfq_pkg::SDATA_W-1:0]  s_tdata,
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [mpfq_pkg::MDATA_W-1:0]       m_tdata,
  output logic [1:0]                         m_tuser
);
  import mpfq_pkg::*;

  logic [ENTRY_W-1:0] mem [LEVELS*LEVEL_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic [HEAD_W-1:0] level_head  [LEVELS];
  logic [CNT_W-1:0]  level_count [LEVELS];

  command_t          in_cmd;
  logic [PRI_W-1:0]  in_pri;
  logic [ID_W-1:0]   in_id;
  logic              in_rdy;

  status_t           res_status;
  logic [PRI_W-1:0]  res_pri;
  logic              res_deq;

  logic [LEVELS-1:0] nonempty;
  logic [LVL_W-1:0]  top_lvl;
  logic [PRI_W-1:0]  enq_pri_m1;
  logic [LVL_W-1:0]  idx;
  logic              pri_ok;
  logic [HEAD_W-1:0] head_sel;
  logic [CNT_W-1:0]  cnt_sel;
  logic [SUM_W-1:0]  sum;
  logic [HEAD_W-1:0] slot;
  logic [HEAD_W-1:0] addr_off;
  logic [ADDR_W-1:0] addr;
  logic              do_enq;
  logic              do_deq;
  status_t           status_next;

  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (level_count[i] != '0);
      if (nonempty[i]) begin
        top_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    enq_pri_m1 = in_pri - PRI_W'(1);
    pri_ok     = (in_pri != '0) && (in_pri <= PRI_W'(LEVELS));
    idx        = (in_cmd == CMD_DEQ) ? top_lvl : enq_pri_m1[LVL_W-1:0];
    head_sel   = level_head[idx];
    cnt_sel    = level_count[idx];
    sum        = SUM_W'(head_sel) + SUM_W'(cnt_sel);
    if (sum >= SUM_W'(LEVEL_DEPTH)) begin
      sum = sum - SUM_W'(LEVEL_DEPTH);
    end
    slot     = sum[HEAD_W-1:0];
    addr_off = (in_cmd == CMD_DEQ) ? head_sel : slot;
    addr     = ADDR_W'(idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(addr_off);
    do_enq   = 1'b0;
    do_deq   = 1'b0;
    priority if (in_cmd == CMD_DEQ) begin
      if (nonempty == '0) begin
        status_next = ST_EMPTY;
      end else begin
        status_next = ST_OK;
        do_deq      = 1'b1;
      end
    end else if (!pri_ok) begin
      status_next = ST_BADPRI;
    end else if (cnt_sel == CNT_W'(LEVEL_DEPTH)) begin
      status_next = ST_FULL;
    end else begin
      status_next = ST_OK;
      do_enq      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_cmd <= command_t'(s_tuser);
      in_pri <= s_tdata[PRI_W-1:0];
      in_id  <= s_tdata[PRI_W+ID_W-1:PRI_W];
      in_rdy <= s_tdata[PRI_W+ID_W];
    end
    if (cmd.exec) begin
      res_status <= status_next;
      res_deq    <= do_deq;
      res_pri    <= PRI_W'(top_lvl) + PRI_W'(1);
      if (do_enq) begin
        mem[addr] <= {in_rdy, in_id};
      end
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        level_head[i]  <= '0;
        level_count[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (do_enq) begin
        level_count[idx] <= cnt_sel + CNT_W'(1);
      end else if (do_deq) begin
        level_count[idx] <= cnt_sel - CNT_W'(1);
        if (head_sel == HEAD_W'(LEVEL_DEPTH - 1)) begin
          level_head[idx] <= '0;
        end else begin
          level_head[idx] <= head_sel + HEAD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= res_status;
      if (res_deq) begin
        m_tdata <= {{MDATA_PAD{1'b0}}, res_pri, rd_data};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

endmodule
`default_nettype wire

/* src/mpfq_checker.sv */
`default_nettype none
module mpfq_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [mpfq_pkg::MDATA_W-1:0] m_tdata,
  input wire logic [1:0]                   m_tuser
);
  import mpfq_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Output beat changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output valid after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input accepted while a beat is in progress.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
    else $error("Failed request carries nonzero data.");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ENTRY_W+PRI_W-1:ENTRY_W] <= PRI_W'(LEVELS)))
    else $error("Dequeued level out of range.");

endmodule

bind multilevel_priority_fifo_queue_unit mpfq_checker u_mpfq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

/* dv/tb_multilevel_priority_fifo_queue_unit.sv */
`timescale 1ns / 100ps
module tb_multilevel_priority_fifo_queue_unit;
  import mpfq_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    command_t cmd;
    logic [PRI_W-1:0] pri;
    logic [ID_W-1:0] id;
    logic rdy;
  } sched_req_t;

  typedef struct packed {
    status_t status;
    logic [ID_W-1:0] id;
    logic rdy;
    logic [PRI_W-1:0] lvl;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  multilevel_priority_fifo_queue_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // Shadow of the ready queue: per-level slots, head and occupancy.
  logic [ENTRY_W-1:0] lvl_slots [LEVELS][LEVEL_DEPTH];
  logic [HEAD_W-1:0] lvl_head [LEVELS];
  logic [CNT_W-1:0] lvl_cnt [LEVELS];

  sched_req_t pending_reqs[$];
  sched_result_t sched_due[$];
  sched_req_t next_req;
  int mismatches = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold_left = 0;
  bit rx_hold_req = 1'b0;
  bit idle_on = 1'b0;
  bit req_taken = 1'b0;
  bit beat_seen = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic sched_result_t schedule_result(sched_req_t req);
    sched_result_t res;
    int lvl;
    int slot;
    res.status = ST_OK;
    res.id = '0;
    res.rdy = 1'b0;
    res.lvl = '0;
    if (req.cmd == CMD_ENQ) begin
      if (req.pri == 0 || req.pri > LEVELS) begin
        res.status = ST_BADPRI;
      end else begin
        lvl = req.pri - 1;
        if (lvl_cnt[lvl] >= LEVEL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = (int'(lvl_head[lvl]) + int'(lvl_cnt[lvl])) % LEVEL_DEPTH;
          lvl_slots[lvl][slot] = {req.rdy, req.id};
          lvl_cnt[lvl] = lvl_cnt[lvl] + CNT_W'(1);
        end
      end
    end else begin
      lvl = -1;
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (lvl < 0 && lvl_cnt[i] != 0) lvl = i;
      end
      if (lvl < 0) begin
        res.status = ST_EMPTY;
      end else begin
        {res.rdy, res.id} = lvl_slots[lvl][lvl_head[lvl]];
        res.lvl = PRI_W'(lvl + 1);
        if (lvl_head[lvl] == LEVEL_DEPTH - 1) lvl_head[lvl] = '0;
        else lvl_head[lvl] = lvl_head[lvl] + HEAD_W'(1);
        lvl_cnt[lvl] = lvl_cnt[lvl] - CNT_W'(1);
      end
    end
    return res;
  endfunction

  function automatic void push_req(command_t cmd, int pri, int id, int rdy);
    sched_req_t req;
    req.cmd = cmd;
    req.pri = PRI_W'(pri);
    req.id = ID_W'(id);
    req.rdy = rdy[0];
    pending_reqs.push_back(req);
  endfunction

  function automatic void push_random(int n_items);
    int done;
    int lvl;
    int len;
    int r;
    int bad_pri;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        lvl = $urandom_range(1, LEVELS);
        len = LEVEL_DEPTH + $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_req(CMD_ENQ, lvl, $urandom, $urandom_range(0, 1));
      end else if (r < 30) begin
        len = $urandom_range(10, 40);
        for (int i = 0; i < len; i++) begin
          push_req(CMD_DEQ, $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
        end
      end else begin
        len = $urandom_range(10, 30);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            push_req(CMD_ENQ, $urandom_range(1, LEVELS), $urandom, $urandom_range(0, 1));
          end else if (r < 56) begin
            bad_pri = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(LEVELS + 1, 15);
            push_req(CMD_ENQ, bad_pri, $urandom, $urandom_range(0, 1));
          end else begin
            push_req(CMD_DEQ, $urandom_range(0, 15), $urandom, $urandom_range(0, 1));
          end
        end
      end
      done += len;
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || sched_due.size() != 0);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(0, 11);
        s_tvalid <= 1'b0;
      end else begin
        next_req = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_req.cmd;
        s_tdata <= SDATA_W'({next_req.rdy, next_req.id, next_req.pri});
      end
    end
    req_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_req_t req;
    sched_result_t got;
    sched_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req.cmd = command_t'(s_tuser);
        req.pri = s_tdata[3:0];
        req.id = s_tdata[19:4];
        req.rdy = s_tdata[20];
        sched_due.push_back(schedule_result(req));
        req_taken = 1'b1;
        beat_seen = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        beat_seen = 1'b1;
        got.status = status_t'(m_tuser);
        got.id = m_tdata[15:0];
        got.rdy = m_tdata[16];
        got.lvl = m_tdata[20:17];
        if (sched_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result beat with no request outstanding: status %0d id %h rdy %b lvl %0d",
                     got.status, got.id, got.rdy, got.lvl);
          end
        end else begin
          want = sched_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: exp st %0d id %h rdy %b lvl %0d, got st %0d id %h rdy %b lvl %0d",
                       want.status, want.id, want.rdy, want.lvl,
                       got.status, got.id, got.rdy, got.lvl);
            end
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (beat_seen || rst) quiet = 0;
      else quiet++;
      beat_seen = 1'b0;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int lvl;
    for (int i = 0; i < LEVELS; i++) begin
      lvl_head[i] = '0;
      lvl_cnt[i] = '0;
      for (int j = 0; j < LEVEL_DEPTH; j++) lvl_slots[i][j] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty queue, out-of-range priorities, then two tasks per corner level and
    // one at level 4, dequeued in priority order and FIFO order within a level.
    push_req(CMD_DEQ, 15, 'hFFFF, 1);
    push_req(CMD_ENQ, 0, 'hFFFF, 1);
    push_req(CMD_ENQ, 15, 'h0000, 0);
    push_req(CMD_ENQ, LEVELS + 1, 'hAAAA, 1);
    push_req(CMD_ENQ, 1, 'h0000, 0);
    push_req(CMD_ENQ, LEVELS, 'hFFFF, 1);
    push_req(CMD_ENQ, 4, 'h5555, 1);
    push_req(CMD_ENQ, LEVELS, 'h0001, 0);
    push_req(CMD_ENQ, 1, 'h8000, 1);
    for (int i = 0; i < 6; i++) push_req(CMD_DEQ, i * 3, 'h1234 * i, i % 2);

    idle_on = 1'b1;
    push_random(380);
    wait_drained();

    // Receiver stalls while one level is pushed past full.
    rx_hold_req = 1'b1;
    lvl = $urandom_range(1, LEVELS);
    for (int i = 0; i < LEVEL_DEPTH - int'(lvl_cnt[lvl - 1]) + 3; i++) begin
      push_req(CMD_ENQ, lvl, $urandom, $urandom_range(0, 1));
    end
    for (int i = 0; i < 8; i++) push_req(CMD_DEQ, $urandom_range(0, 15), $urandom, 0);
    wait_drained();

    push_random(130);
    wait_drained();
    idle_on = 1'b0;
    push_random(100);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mpfq_pkg.sv
src/mpfq_ctrl.sv
src/mpfq_dpath.sv
src/multilevel_priority_fifo_queue_unit.sv
src/mpfq_checker.sv
dv/tb_multilevel_priority_fifo_queue_unit.sv
